// ===== rtl/ske_pkg.sv =====
// shared widths, datapath operation codes and controller/datapath bundles
package ske_pkg;

    // fixed field widths
    localparam int SAMPLE_W   = 8;
    localparam int EST_W      = 24;
    localparam int GAIN_W     = 16;
    localparam int COV_W      = 26;
    localparam int CFG_W      = 24;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // datapath operations issued by the controller
    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_DIV,
        OP_GAIN,
        OP_MULX,
        OP_UPDX,
        OP_MULP,
        OP_UPDP
    } dp_op_t;

    // controller to datapath
    typedef struct packed {
        dp_op_t op;
        logic   out_load;
    } ske_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_done;
    } ske_status_t;

endpackage

// ===== rtl/scalar_kalman_estimator_top.sv =====
// scalar kalman estimator top level: configuration registers, controller, datapath
//
//  channel  direction  handshake               payload
//  config   in         psel/penable/pready     paddr, pwdata, prdata
//  input    in         in_valid / in_stall     sample
//  output   out        out_valid / out_stall   estimate, gain, covariance
//
//  one transaction runs from acceptance through the radix-2 gain divider, one quotient
//  bit a cycle, then the gain, estimate and covariance steps, before the next acceptance
//  the covariance and estimate updates share one multiplier
//  a finished result waits in the output register; a new sample is accepted meanwhile,
//  and only the result load of that next transaction waits on out_stall
//  reset is asynchronous; no clearing pass, the block is ready right after reset
module scalar_kalman_estimator_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ske_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ske_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ske_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [ske_pkg::SAMPLE_W-1:0]    sample,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ske_pkg::EST_W-1:0]       estimate,
    output logic [ske_pkg::GAIN_W-1:0]      gain,
    output logic [ske_pkg::COV_W-1:0]       covariance
);
    import ske_pkg::*;

    typedef enum logic {
        REG_PROCESS_NOISE,
        REG_MEASUREMENT_NOISE
    } reg_idx_t;

    localparam logic [CFG_W-1:0] CFG_MAX = '1;
    // 0.01 and 1.0 in the fixed-point format
    localparam logic [63:0]      Q_RST_L = (64'd1 << FRAC_BITS) / 64'd100;
    localparam logic [63:0]      R_RST_L = 64'd1 << FRAC_BITS;
    localparam logic [CFG_W-1:0] Q_RST   = (Q_RST_L > 64'(CFG_MAX)) ? CFG_MAX
                                                                     : Q_RST_L[CFG_W-1:0];
    localparam logic [CFG_W-1:0] R_RST   = (R_RST_L > 64'(CFG_MAX)) ? CFG_MAX
                                                                     : R_RST_L[CFG_W-1:0];

    logic [CFG_W-1:0] process_noise_reg,     process_noise_next;
    logic [CFG_W-1:0] measurement_noise_reg, measurement_noise_next;
    logic             cfg_wr;
    reg_idx_t         reg_sel;
    ske_cmd_t         cmd;
    ske_status_t      status;

    // register write decode
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = reg_idx_t'(paddr[2]);

    always_comb
    begin
        process_noise_next     = process_noise_reg;
        measurement_noise_next = measurement_noise_reg;
        if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_PROCESS_NOISE:     process_noise_next     = pwdata[CFG_W-1:0];
                REG_MEASUREMENT_NOISE: measurement_noise_next = pwdata[CFG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            process_noise_reg     <= Q_RST;
            measurement_noise_reg <= R_RST;
        end
        else
        begin
            process_noise_reg     <= process_noise_next;
            measurement_noise_reg <= measurement_noise_next;
        end
    end

    // register read mux
    always_comb
    begin
        unique case (reg_sel)
            REG_PROCESS_NOISE:     prdata = APB_DATA_W'(process_noise_reg);
            REG_MEASUREMENT_NOISE: prdata = APB_DATA_W'(measurement_noise_reg);
            default:               prdata = '0;
        endcase
    end

    // sequencing
    ske_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    // arithmetic and filter state
    ske_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .sample            (sample),
        .process_noise     (process_noise_reg),
        .measurement_noise (measurement_noise_reg),
        .estimate          (estimate),
        .gain              (gain),
        .covariance        (covariance)
    );

endmodule

// ===== rtl/ske_datapath.sv =====
// kalman update datapath: prediction, radix-2 gain divider, shared multiplier, state
module ske_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ske_pkg::ske_cmd_t              cmd,
    output ske_pkg::ske_status_t           status,
    input  logic [ske_pkg::SAMPLE_W-1:0]   sample,
    input  logic [ske_pkg::CFG_W-1:0]      process_noise,
    input  logic [ske_pkg::CFG_W-1:0]      measurement_noise,
    output logic [ske_pkg::EST_W-1:0]      estimate,
    output logic [ske_pkg::GAIN_W-1:0]     gain,
    output logic [ske_pkg::COV_W-1:0]      covariance
);
    import ske_pkg::*;

    localparam int DEN_W  = COV_W + 1;
    localparam int REM_W  = DEN_W + 1;
    localparam int CNT_W  = $clog2(FRAC_BITS);
    localparam int MAG_W  = (SAMPLE_W + FRAC_BITS > EST_W) ? SAMPLE_W + FRAC_BITS : EST_W;
    localparam int MA_W   = FRAC_BITS + 1;
    localparam int MB_W   = (MAG_W > COV_W) ? MAG_W : COV_W;
    localparam int PROD_W = MA_W + MB_W;

    localparam logic [EST_W-1:0] EST_MAX = '1;
    localparam logic [COV_W-1:0] COV_MAX = '1;

    // one, gain limit and reset state in the chosen fixed-point format
    localparam logic [63:0] ONE_L   = 64'd1 << FRAC_BITS;
    localparam logic [63:0] GMAX_L  = (FRAC_BITS >= GAIN_W) ? ((64'd1 << GAIN_W) - 64'd1)
                                                             : (ONE_L - 64'd1);
    // 127.5 and 100.0
    localparam logic [63:0] X_RST_L = 64'd255 << (FRAC_BITS - 1);
    localparam logic [63:0] P_RST_L = 64'd100 << FRAC_BITS;

    localparam logic [EST_W-1:0]     X_RST  = (X_RST_L > 64'(EST_MAX)) ? EST_MAX
                                                                        : X_RST_L[EST_W-1:0];
    localparam logic [COV_W-1:0]     P_RST  = (P_RST_L > 64'(COV_MAX)) ? COV_MAX
                                                                        : P_RST_L[COV_W-1:0];
    localparam logic [MA_W-1:0]      ONE    = ONE_L[MA_W-1:0];
    localparam logic [PROD_W-1:0]    HALF   = PROD_W'(ONE_L >> 1);
    localparam logic [FRAC_BITS-1:0] GMAX_Q = GMAX_L[FRAC_BITS-1:0];
    localparam logic [GAIN_W-1:0]    GMAX_G = GMAX_L[GAIN_W-1:0];

    // filter state
    logic [EST_W-1:0]     est_reg,  est_next;
    logic [COV_W-1:0]     cov_reg,  cov_next;

    // per-transaction working registers
    logic [SAMPLE_W-1:0]  sample_reg, sample_next;
    logic [COV_W-1:0]     ppred_reg,  ppred_next;
    logic [DEN_W-1:0]     den_reg,    den_next;
    logic [REM_W-1:0]     rem_reg,    rem_next;
    logic [FRAC_BITS-1:0] quo_reg,    quo_next;
    logic [CNT_W-1:0]     cnt_reg,    cnt_next;
    logic [GAIN_W-1:0]    gain_reg,   gain_next;
    logic                 up_reg,     up_next;
    logic [MAG_W-1:0]     mag_reg,    mag_next;
    logic [PROD_W-1:0]    prod_reg,   prod_next;

    // result registers
    logic [EST_W-1:0]     estimate_reg;
    logic [GAIN_W-1:0]    gain_out_reg;
    logic [COV_W-1:0]     covariance_reg;

    // combinational intermediates
    logic [DEN_W-1:0]     psum;
    logic [COV_W-1:0]     ppred_sat;
    logic [REM_W-1:0]     rem_dbl;
    logic [REM_W-1:0]     den_ext;
    logic                 rem_ge;
    logic [MAG_W-1:0]     target;
    logic [MAG_W-1:0]     est_mag;
    logic                 tgt_up;
    logic [MA_W-1:0]      mul_a;
    logic [MB_W-1:0]      mul_b;
    logic [PROD_W-1:0]    mul_p;
    logic [PROD_W-1:0]    rounded;
    logic [PROD_W-1:0]    adj;
    logic [PROD_W-1:0]    est_ext;
    logic [PROD_W-1:0]    est_up;
    logic [PROD_W-1:0]    est_dn;

    // shared multiplier: gain times distance, or one minus gain times prediction
    always_comb
    begin
        if (cmd.op == OP_MULP)
        begin
            mul_a = ONE - MA_W'(gain_reg);
            mul_b = MB_W'(ppred_reg);
        end
        else
        begin
            mul_a = MA_W'(gain_reg);
            mul_b = MB_W'(mag_reg);
        end
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // intermediate values
    always_comb
    begin
        psum      = DEN_W'(cov_reg) + DEN_W'(process_noise);
        ppred_sat = psum[COV_W] ? COV_MAX : psum[COV_W-1:0];
        rem_dbl   = {rem_reg[REM_W-2:0], 1'b0};
        den_ext   = REM_W'(den_reg);
        rem_ge    = (rem_dbl >= den_ext);
        target    = MAG_W'({sample_reg, {FRAC_BITS{1'b0}}});
        est_mag   = MAG_W'(est_reg);
        tgt_up    = (target >= est_mag);
        rounded   = prod_reg + HALF;
        adj       = rounded >> FRAC_BITS;
        est_ext   = PROD_W'(est_reg);
        est_up    = est_ext + adj;
        est_dn    = est_ext - adj;
    end

    // next-value selection by operation
    always_comb
    begin
        est_next    = est_reg;
        cov_next    = cov_reg;
        sample_next = sample_reg;
        ppred_next  = ppred_reg;
        den_next    = den_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        cnt_next    = cnt_reg;
        gain_next   = gain_reg;
        up_next     = up_reg;
        mag_next    = mag_reg;
        prod_next   = prod_reg;
        case (cmd.op)
            // predicted covariance and divider setup
            OP_LOAD:
            begin
                sample_next = sample;
                ppred_next  = ppred_sat;
                den_next    = DEN_W'(ppred_sat) + DEN_W'(measurement_noise);
                rem_next    = REM_W'(ppred_sat);
                quo_next    = '0;
                cnt_next    = '0;
            end
            // one restoring quotient bit
            OP_DIV:
            begin
                rem_next = rem_ge ? (rem_dbl - den_ext) : rem_dbl;
                quo_next = {quo_reg[FRAC_BITS-2:0], rem_ge};
                cnt_next = cnt_reg + 1'b1;
            end
            // capped gain, distance from estimate to sample
            OP_GAIN:
            begin
                if (den_reg == '0)
                    gain_next = '0;
                else if (quo_reg > GMAX_Q)
                    gain_next = GMAX_G;
                else
                    gain_next = GAIN_W'(quo_reg);
                up_next  = tgt_up;
                mag_next = tgt_up ? (target - est_mag) : (est_mag - target);
            end
            OP_MULX, OP_MULP:
            begin
                prod_next = mul_p;
            end
            // move estimate, clamped to the field
            OP_UPDX:
            begin
                if (up_reg)
                    est_next = (est_up > PROD_W'(EST_MAX)) ? EST_MAX : est_up[EST_W-1:0];
                else
                    est_next = (adj > est_ext) ? '0 : est_dn[EST_W-1:0];
            end
            // shrink covariance, saturating
            OP_UPDP:
            begin
                cov_next = (adj > PROD_W'(COV_MAX)) ? COV_MAX : adj[COV_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    // filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            est_reg <= X_RST;
            cov_reg <= P_RST;
        end
        else
        begin
            est_reg <= est_next;
            cov_reg <= cov_next;
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        ppred_reg  <= ppred_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        cnt_reg    <= cnt_next;
        gain_reg   <= gain_next;
        up_reg     <= up_next;
        mag_reg    <= mag_next;
        prod_reg   <= prod_next;
        if (cmd.out_load)
        begin
            estimate_reg   <= est_reg;
            gain_out_reg   <= gain_reg;
            covariance_reg <= cov_reg;
        end
    end

    assign status.div_done = (cnt_reg == CNT_W'(FRAC_BITS - 1));

    assign estimate   = estimate_reg;
    assign gain       = gain_out_reg;
    assign covariance = covariance_reg;

endmodule

// ===== rtl/ske_ctrl.sv =====
// sequencing controller: input and output handshakes, datapath operation order
module ske_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  logic                  out_stall,
    output ske_pkg::ske_cmd_t     cmd,
    input  ske_pkg::ske_status_t  status
);
    import ske_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_GAIN,
        S_MULX,
        S_UPDX,
        S_MULP,
        S_UPDP,
        S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    // result register can take a new transaction
    assign out_free = !out_valid_reg || !out_stall;

    // next state and operation decode
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.op         = OP_NOP;
        cmd.out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.op = OP_DIV;
                if (status.div_done)
                    state_next = S_GAIN;
            end
            S_GAIN:
            begin
                cmd.op     = OP_GAIN;
                state_next = S_MULX;
            end
            S_MULX:
            begin
                cmd.op     = OP_MULX;
                state_next = S_UPDX;
            end
            S_UPDX:
            begin
                cmd.op     = OP_UPDX;
                state_next = S_MULP;
            end
            S_MULP:
            begin
                cmd.op     = OP_MULP;
                state_next = S_UPDP;
            end
            S_UPDP:
            begin
                cmd.op     = OP_UPDP;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    // an accepted transaction starts the divider
    a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_DIV))
        else $error("accepted transaction did not start the divider");

    // the divider runs until the datapath reports its last step
    a_div_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && !status.div_done) |=> (state_reg == S_DIV))
        else $error("divider left before its last step");

    // a new result only appears from the finish state
    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result raised outside the finish state");

endmodule

// ===== sim/tb_top.sv =====
// testbench for the scalar kalman estimator: directed table, random samples, in-order transaction predictor
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ske_pkg::*;

    localparam int FRAC       = 16;
    localparam int CYCLE_CAP  = 1000000;
    localparam int LONG_HOLD  = 600;
    localparam int SETTLE     = 40;
    localparam int RAND_PHASES = 7;
    localparam int PHASE_ITEMS = 200;
    localparam int FILL_ITEMS  = 20;
    localparam int NUM_ROWS    = 18;

    // register byte addresses
    localparam logic [APB_ADDR_W-1:0] ADDR_PROC_NOISE = 3'd0;
    localparam logic [APB_ADDR_W-1:0] ADDR_MEAS_NOISE = 3'd4;

    // fixed-point constants at 16 fraction bits
    localparam logic [63:0] ONE      = 64'd1 << FRAC;
    localparam logic [63:0] HALF     = ONE >> 1;
    localparam logic [63:0] GAIN_MAX = 64'd65535;
    localparam logic [63:0] EST_MAX  = (64'd1 << EST_W) - 1;
    localparam logic [63:0] COV_MAX  = (64'd1 << COV_W) - 1;
    localparam logic [CFG_W-1:0] NOISE_MAX = {CFG_W{1'b1}};
    localparam logic [CFG_W-1:0] Q_RESET   = 24'd655;
    localparam logic [CFG_W-1:0] R_RESET   = 24'd65536;
    localparam logic [EST_W-1:0] EST_RESET = 24'd8355840;
    localparam logic [COV_W-1:0] COV_RESET = 26'd6553600;

    typedef struct packed {
        logic [EST_W-1:0]  est;
        logic [GAIN_W-1:0] gain;
        logic [COV_W-1:0]  cov;
    } kalman_out_t;

    typedef struct packed {
        logic [CFG_W-1:0]    q;
        logic [CFG_W-1:0]    r;
        logic [SAMPLE_W-1:0] smp;
        logic                gain_known;
        logic [GAIN_W-1:0]   gain_val;
    } sample_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_stall;
    logic [SAMPLE_W-1:0]   sample;
    logic                  out_valid;
    logic                  out_stall;
    logic [EST_W-1:0]      estimate;
    logic [GAIN_W-1:0]     gain;
    logic [COV_W-1:0]      covariance;

    // predictor copy of filter state and noise settings
    logic [EST_W-1:0] est_state;
    logic [COV_W-1:0] cov_state;
    logic [CFG_W-1:0] q_cfg;
    logic [CFG_W-1:0] r_cfg;

    kalman_out_t pending_updates [$];
    kalman_out_t oldest_update;
    sample_row_t directed_rows [0:NUM_ROWS-1];
    int          mismatch_count;
    int          cycle_count;
    int          burst_left;
    bit          hold_armed;
    bit          hold_done;

    scalar_kalman_estimator_top #(
        .FRAC_BITS (FRAC)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample     (sample),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .estimate   (estimate),
        .gain       (gain),
        .covariance (covariance)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_CAP)
            begin
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    // one kalman step: gain from predicted covariance, estimate and covariance update
    function automatic kalman_out_t kalman_update(input logic [SAMPLE_W-1:0] smp);
        logic [63:0] ppred;
        logic [63:0] den;
        logic [63:0] k;
        logic [63:0] target;
        logic [63:0] mag;
        logic [63:0] adj;
        logic [63:0] xnew;
        logic [63:0] pnew;
        logic        up;
        kalman_out_t res;
        ppred = 64'(cov_state) + 64'(q_cfg);
        if (ppred > COV_MAX)
            ppred = COV_MAX;
        den = ppred + 64'(r_cfg);
        if (den == 64'd0)
            k = 64'd0;
        else
            k = (ppred << FRAC) / den;
        if (k > GAIN_MAX)
            k = GAIN_MAX;
        // move toward the sample, magnitude rounded half away from zero
        target = 64'(smp) << FRAC;
        up = (target >= 64'(est_state));
        mag = up ? (target - 64'(est_state)) : (64'(est_state) - target);
        adj = (k * mag + HALF) >> FRAC;
        if (up)
            xnew = (64'(est_state) + adj > EST_MAX) ? EST_MAX : 64'(est_state) + adj;
        else
            xnew = (adj > 64'(est_state)) ? 64'd0 : 64'(est_state) - adj;
        // shrink covariance by one minus gain, saturating
        pnew = ((ONE - k) * ppred + HALF) >> FRAC;
        if (pnew > COV_MAX)
            pnew = COV_MAX;
        est_state = xnew[EST_W-1:0];
        cov_state = pnew[COV_W-1:0];
        res.est  = xnew[EST_W-1:0];
        res.gain = k[GAIN_W-1:0];
        res.cov  = pnew[COV_W-1:0];
        return res;
    endfunction

    // one apb transfer: setup cycle, then access until pready
    task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] wdata,
                              output logic [APB_DATA_W-1:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // read a noise register and compare
    task automatic check_noise_reg(input logic [APB_ADDR_W-1:0] addr,
                                   input logic [CFG_W-1:0] want, input string name);
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b0, addr, '0, rd);
        if (rd !== APB_DATA_W'(want))
        begin
            $error("%s: expected %0d, actual %0d", name, want, rd);
            mismatch_count++;
        end
    endtask

    // write both noise registers, read them back
    task automatic set_noise(input logic [CFG_W-1:0] q, input logic [CFG_W-1:0] r);
        logic [APB_DATA_W-1:0] rd;
        apb_access(1'b1, ADDR_PROC_NOISE, APB_DATA_W'(q), rd);
        apb_access(1'b1, ADDR_MEAS_NOISE, APB_DATA_W'(r), rd);
        q_cfg = q;
        r_cfg = r;
        check_noise_reg(ADDR_PROC_NOISE, q, "process_noise");
        check_noise_reg(ADDR_MEAS_NOISE, r, "measurement_noise");
    endtask

    // offer one sample and predict its update once accepted
    task automatic offer_sample(input logic [SAMPLE_W-1:0] smp, input logic pin,
                                input logic [GAIN_W-1:0] pin_gain);
        kalman_out_t want;
        in_valid <= 1'b1;
        sample   <= smp;
        do
            @(posedge clk);
        while (in_stall);
        want = kalman_update(smp);
        if (pin)
            want.gain = pin_gain;
        pending_updates.push_back(want);
    endtask

    // sender bursts with random gaps between them
    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
    endtask

    // stop offering and wait until every update has come out
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_updates.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [CFG_W-1:0] pick_noise(input logic [CFG_W-1:0] lo);
        case ($urandom_range(0, 4))
            0: return lo;
            1: return NOISE_MAX;
            2: return CFG_W'($urandom_range(lo, 4 * 65536));
            default: return CFG_W'($urandom_range(lo, NOISE_MAX));
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] last);
        int v;
        case ($urandom_range(0, 9))
            6: v = 0;
            7: v = 255;
            8, 9: v = int'(last) + $urandom_range(0, 8) - 4;
            default: v = $urandom_range(0, 255);
        endcase
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return SAMPLE_W'(v);
    endfunction

    // receiver stall pattern, with one long hold-off once armed
    initial
    begin : rx_pattern
        int mode;
        int len;
        out_stall = 1'b0;
        hold_done = 1'b0;
        forever
        begin
            if (hold_armed && !hold_done)
            begin
                hold_done = 1'b1;
                repeat (LONG_HOLD)
                begin
                    @(posedge clk);
                    out_stall <= 1'b1;
                end
            end
            mode = $urandom_range(0, 3);
            len  = $urandom_range(1, 80);
            repeat (len)
            begin
                @(posedge clk);
                out_stall <= (mode != 0) && ($urandom_range(0, 3) < mode);
            end
        end
    end

    // compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_updates.size() == 0)
            begin
                $error("result transaction with no prediction waiting");
                mismatch_count++;
            end
            else
            begin
                oldest_update = pending_updates.pop_front();
                if (estimate !== oldest_update.est)
                begin
                    $error("estimate: expected %0d, actual %0d", oldest_update.est, estimate);
                    mismatch_count++;
                end
                if (gain !== oldest_update.gain)
                begin
                    $error("gain: expected %0d, actual %0d", oldest_update.gain, gain);
                    mismatch_count++;
                end
                if (covariance !== oldest_update.cov)
                begin
                    $error("covariance: expected %0d, actual %0d", oldest_update.cov,
                           covariance);
                    mismatch_count++;
                end
            end
        end
    end

    // main sequence
    initial
    begin : main_seq
        logic [SAMPLE_W-1:0] smp;
        logic [CFG_W-1:0]    cur_q;
        logic [CFG_W-1:0]    cur_r;
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_valid       = 1'b0;
        sample         = '0;
        mismatch_count = 0;
        burst_left     = 0;
        hold_armed     = 1'b0;
        est_state      = EST_RESET;
        cov_state      = COV_RESET;
        q_cfg          = Q_RESET;
        r_cfg          = R_RESET;

        // directed rows: reset noise, gain pinned at its cap, tiny and huge noise
        directed_rows = '{
            '{Q_RESET,   R_RESET,   8'd0,   1'b0, 16'd0},
            '{Q_RESET,   R_RESET,   8'd255, 1'b0, 16'd0},
            '{Q_RESET,   R_RESET,   8'd128, 1'b0, 16'd0},
            '{Q_RESET,   R_RESET,   8'd127, 1'b0, 16'd0},
            '{Q_RESET,   R_RESET,   8'd1,   1'b0, 16'd0},
            '{Q_RESET,   R_RESET,   8'd254, 1'b0, 16'd0},
            '{Q_RESET,   R_RESET,   8'd85,  1'b0, 16'd0},
            '{Q_RESET,   R_RESET,   8'd170, 1'b0, 16'd0},
            '{NOISE_MAX, 24'd1,     8'd0,   1'b1, 16'd65535},
            '{NOISE_MAX, 24'd1,     8'd255, 1'b1, 16'd65535},
            '{NOISE_MAX, 24'd1,     8'd0,   1'b1, 16'd65535},
            '{NOISE_MAX, 24'd1,     8'd255, 1'b1, 16'd65535},
            '{24'd0,     NOISE_MAX, 8'd255, 1'b0, 16'd0},
            '{24'd0,     NOISE_MAX, 8'd0,   1'b0, 16'd0},
            '{24'd0,     NOISE_MAX, 8'd200, 1'b0, 16'd0},
            '{NOISE_MAX, NOISE_MAX, 8'd0,   1'b0, 16'd0},
            '{NOISE_MAX, NOISE_MAX, 8'd255, 1'b0, 16'd0},
            '{NOISE_MAX, NOISE_MAX, 8'd60,  1'b0, 16'd0}
        };

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset values of the noise registers
        check_noise_reg(ADDR_PROC_NOISE, Q_RESET, "process_noise");
        check_noise_reg(ADDR_MEAS_NOISE, R_RESET, "measurement_noise");
        @(posedge clk);

        // directed part
        cur_q = Q_RESET;
        cur_r = R_RESET;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].q != cur_q || directed_rows[i].r != cur_r)
            begin
                drain();
                cur_q = directed_rows[i].q;
                cur_r = directed_rows[i].r;
                set_noise(cur_q, cur_r);
                @(posedge clk);
            end
            offer_sample(directed_rows[i].smp, directed_rows[i].gain_known,
                         directed_rows[i].gain_val);
            pace();
        end

        // random part, a fresh noise setting per phase
        smp = 8'd128;
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            drain();
            set_noise(pick_noise(24'd0), pick_noise(24'd1));
            @(posedge clk);
            // back-to-back transactions against a long output hold-off
            if (p == 1)
            begin
                hold_armed = 1'b1;
                repeat (FILL_ITEMS)
                begin
                    smp = pick_sample(smp);
                    offer_sample(smp, 1'b0, '0);
                end
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                smp = pick_sample(smp);
                offer_sample(smp, 1'b0, '0);
                pace();
            end
        end

        drain();
        if (mismatch_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
